/* rtl/core/ochm_pkg.sv */
// Request and status codes shared by the ordered chained hash map.
package ochm_pkg;

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_SET    = 2'd1,
      OP_DELETE = 2'd2,
      OP_NEXT   = 2'd3
   } req_op_type;

   typedef enum logic [2:0] {
      ST_HIT      = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_UPDATED  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   localparam int HASH_BITS = 32;
   localparam int POS_BITS  = 8;

endpackage

/* rtl/core/ochm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module ochm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/ordered_chained_hash_map.sv */
// Ordered chained hash map with insertion order, tombstones and in-place compaction.
//
//   channel  ports                                   handshake
//   request  req_type req_key req_key_hash req_value start high while busy low
//            req_position
//   result   rsp_status rsp_out_key rsp_out_value    rsp_valid, one cycle, no stall
//            rsp_next_position
//
// Get, set and delete read the bucket head, then check each chain entry visited; an insert
// adds a head read and a write. Next scans entries from the start position up to the first
// live entry or the fill mark. A set that finds the append area full with dead entries
// first compacts: it clears the bucket heads, then moves each live entry down and relinks it.
// After reset the bucket head memory is cleared with busy high.
// Results cannot be stalled; busy holds off the next request until the result is out.
module ordered_chained_hash_map #(
   parameter int BUCKET_COUNT = 256,
   parameter int ENTRY_COUNT  = 192,
   parameter int KEY_BITS     = 64,
   parameter int VALUE_BITS   = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ochm_pkg::req_op_type   req_type,
   input  logic [KEY_BITS-1:0]    req_key,
   input  logic [31:0]            req_key_hash,
   input  logic [VALUE_BITS-1:0]  req_value,
   input  logic [7:0]             req_position,
   output logic                   rsp_valid,
   output ochm_pkg::status_type   rsp_status,
   output logic [KEY_BITS-1:0]    rsp_out_key,
   output logic [VALUE_BITS-1:0]  rsp_out_value,
   output logic [7:0]             rsp_next_position
);

   import ochm_pkg::*;

   localparam int BA      = $clog2(BUCKET_COUNT);
   localparam int EA      = $clog2(ENTRY_COUNT);
   localparam int CW      = $clog2(ENTRY_COUNT + 1);
   localparam int PW      = (CW > POS_BITS) ? CW : POS_BITS;
   localparam int LIVE_B  = 0;
   localparam int LINK_LO = 1;
   localparam int HASH_LO = LINK_LO + CW;
   localparam int VAL_LO  = HASH_LO + HASH_BITS;
   localparam int KEY_LO  = VAL_LO + VALUE_BITS;
   localparam int EW      = KEY_LO + KEY_BITS;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_HEAD, S_WALK, S_CHK, S_INS_RD, S_INS_WR,
      S_CMP_RD, S_CMP_CHK, S_CMP_HD, S_SCAN, S_SCHK
   } state_type;

   function automatic logic [BA-1:0] bucket_of(input logic [31:0] hash);
      logic [BA:0] b;
      b = {1'b0, hash[31 -: BA]};
      if (b >= (BA+1)'(BUCKET_COUNT)) begin
         b = b - (BA+1)'(BUCKET_COUNT);
      end
      return b[BA-1:0];
   endfunction

   function automatic logic [EW-1:0] pack(input logic [KEY_BITS-1:0] k,
                                          input logic [VALUE_BITS-1:0] v,
                                          input logic [31:0] h,
                                          input logic [CW-1:0] l,
                                          input logic live);
      return {k, v, h, l, live};
   endfunction

   state_type             state_ff;
   req_op_type            op_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [31:0]           hash_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [BA-1:0]         bkt_ff;
   logic [BA-1:0]         clr_ff;
   logic                  cmp_ff;
   logic [CW-1:0]         at_ff;
   logic [CW-1:0]         i_ff;
   logic [CW-1:0]         j_ff;
   logic [PW-1:0]         scan_ff;
   logic [CW-1:0]         fill_ff;
   logic [CW-1:0]         live_ff;
   logic [EW-1:0]         ent_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [KEY_BITS-1:0]   rsp_key_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic [7:0]            rsp_npos_ff;

   logic          b_we;
   logic [BA-1:0] b_waddr, b_raddr;
   logic [CW-1:0] b_wdata, b_rdata;
   logic          e_we;
   logic [EA-1:0] e_waddr, e_raddr;
   logic [EW-1:0] e_wdata, e_rdata;

   logic                  e_live;
   logic [KEY_BITS-1:0]   e_key;
   logic [VALUE_BITS-1:0] e_val;
   logic [31:0]           e_hash;
   logic [CW-1:0]         e_link;
   logic                  match;

   assign e_live = e_rdata[LIVE_B];
   assign e_link = e_rdata[HASH_LO-1:LINK_LO];
   assign e_hash = e_rdata[VAL_LO-1:HASH_LO];
   assign e_val  = e_rdata[KEY_LO-1:VAL_LO];
   assign e_key  = e_rdata[EW-1:KEY_LO];
   assign match  = e_live && (e_key == key_ff);

   ochm_ram #(.WIDTH(CW), .DEPTH(BUCKET_COUNT)) u_bucket (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
      .raddr(b_raddr), .rdata(b_rdata)
   );

   ochm_ram #(.WIDTH(EW), .DEPTH(ENTRY_COUNT)) u_entry (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
      .raddr(e_raddr), .rdata(e_rdata)
   );

   always_comb begin
      b_we    = 1'b0;
      b_waddr = clr_ff;
      b_wdata = '1;
      b_raddr = bucket_of(req_key_hash);
      e_we    = 1'b0;
      e_waddr = at_ff[EA-1:0];
      e_wdata = e_rdata;
      e_raddr = at_ff[EA-1:0];
      case (state_ff)
         S_CLR: begin
            b_we = 1'b1;
         end
         S_CHK: begin
            if (match && op_ff == OP_SET) begin
               e_we    = 1'b1;
               e_wdata = pack(e_key, val_ff, e_hash, e_link, 1'b1);
            end else if (match && op_ff == OP_DELETE) begin
               e_we    = 1'b1;
               e_wdata = pack(e_key, e_val, e_hash, e_link, 1'b0);
            end
         end
         S_INS_RD: begin
            b_raddr = bucket_of(hash_ff);
         end
         S_INS_WR: begin
            b_we    = 1'b1;
            b_waddr = bucket_of(hash_ff);
            b_wdata = fill_ff;
            e_we    = 1'b1;
            e_waddr = fill_ff[EA-1:0];
            e_wdata = pack(key_ff, val_ff, hash_ff, b_rdata, 1'b1);
         end
         S_CMP_RD: begin
            e_raddr = i_ff[EA-1:0];
         end
         S_CMP_CHK: begin
            b_raddr = bucket_of(e_hash);
         end
         S_CMP_HD: begin
            b_we    = 1'b1;
            b_waddr = bkt_ff;
            b_wdata = j_ff;
            e_we    = 1'b1;
            e_waddr = j_ff[EA-1:0];
            e_wdata = {ent_ff[EW-1:HASH_LO], b_rdata, 1'b1};
         end
         S_SCAN: begin
            e_raddr = scan_ff[EA-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         cmp_ff   <= 1'b0;
         fill_ff  <= '0;
         live_ff  <= '0;
      end else begin
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == BA'(BUCKET_COUNT - 1)) begin
                  clr_ff <= '0;
                  i_ff   <= '0;
                  j_ff   <= '0;
                  state_ff <= cmp_ff ? S_CMP_RD : S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  op_ff   <= req_type;
                  key_ff  <= req_key;
                  hash_ff <= req_key_hash;
                  val_ff  <= req_value;
                  scan_ff <= PW'(req_position);
                  state_ff <= (req_type == OP_NEXT) ? S_SCAN : S_HEAD;
               end
            end
            S_HEAD: begin
               at_ff    <= (live_ff == '0) ? '1 : b_rdata;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               if (at_ff < fill_ff) begin
                  state_ff <= S_CHK;
               end else if (op_ff != OP_SET) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_MISS;
                  rsp_key_ff    <= '0;
                  rsp_value_ff  <= '0;
                  rsp_npos_ff   <= '0;
                  state_ff      <= S_IDLE;
               end else if (fill_ff >= CW'(ENTRY_COUNT)) begin
                  if (live_ff < fill_ff) begin
                     cmp_ff   <= 1'b1;
                     clr_ff   <= '0;
                     state_ff <= S_CLR;
                  end else begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_status_ff <= ST_FULL;
                     rsp_key_ff    <= '0;
                     rsp_value_ff  <= '0;
                     rsp_npos_ff   <= '0;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_INS_RD;
               end
            end
            S_CHK: begin
               if (match) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_key_ff   <= '0;
                  rsp_value_ff <= '0;
                  rsp_npos_ff  <= '0;
                  state_ff     <= S_IDLE;
                  case (op_ff)
                     OP_GET: begin
                        rsp_status_ff <= ST_HIT;
                        rsp_value_ff  <= e_val;
                     end
                     OP_SET: begin
                        rsp_status_ff <= ST_UPDATED;
                     end
                     default: begin
                        rsp_status_ff <= ST_HIT;
                        live_ff       <= live_ff - 1'b1;
                     end
                  endcase
               end else begin
                  at_ff    <= e_link;
                  state_ff <= S_WALK;
               end
            end
            S_INS_RD: begin
               state_ff <= S_INS_WR;
            end
            S_INS_WR: begin
               fill_ff       <= fill_ff + 1'b1;
               live_ff       <= live_ff + 1'b1;
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= ST_INSERTED;
               rsp_key_ff    <= '0;
               rsp_value_ff  <= '0;
               rsp_npos_ff   <= '0;
               state_ff      <= S_IDLE;
            end
            S_CMP_RD: begin
               if (i_ff < fill_ff) begin
                  state_ff <= S_CMP_CHK;
               end else begin
                  fill_ff  <= j_ff;
                  live_ff  <= j_ff;
                  cmp_ff   <= 1'b0;
                  state_ff <= S_INS_RD;
               end
            end
            S_CMP_CHK: begin
               if (e_live) begin
                  ent_ff   <= e_rdata;
                  bkt_ff   <= bucket_of(e_hash);
                  state_ff <= S_CMP_HD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_CMP_RD;
               end
            end
            S_CMP_HD: begin
               i_ff     <= i_ff + 1'b1;
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_CMP_RD;
            end
            S_SCAN: begin
               if (scan_ff < PW'(fill_ff)) begin
                  state_ff <= S_SCHK;
               end else begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_MISS;
                  rsp_key_ff    <= '0;
                  rsp_value_ff  <= '0;
                  rsp_npos_ff   <= '0;
                  state_ff      <= S_IDLE;
               end
            end
            S_SCHK: begin
               if (e_live) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= ST_HIT;
                  rsp_key_ff    <= e_key;
                  rsp_value_ff  <= e_val;
                  rsp_npos_ff   <= scan_ff[7:0] + 8'd1;
                  state_ff      <= S_IDLE;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_SCAN;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_key       = rsp_key_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_next_position = rsp_npos_ff;

   a_live_le_fill: assert property (@(posedge clock) disable iff (reset)
      live_ff <= fill_ff) else $error("live count exceeds fill count");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(ENTRY_COUNT)) else $error("fill count beyond capacity");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without a request in work");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results for one item");

endmodule

/* verif/tb_ordered_chained_hash_map.sv */
// Self-checking testbench for the ordered chained hash map.
`timescale 1ns / 100ps

module tb_ordered_chained_hash_map;
   import ochm_pkg::*;

   localparam int BUCKETS = 256;
   localparam int ENTRIES = 192;
   localparam int NO_LINK = -1;

   typedef struct {
      status_type  status;
      logic [63:0] out_key;
      logic [63:0] out_value;
      logic [7:0]  next_position;
   } map_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_op_type  req_type = OP_GET;
   logic [63:0] req_key = '0;
   logic [31:0] req_key_hash = '0;
   logic [63:0] req_value = '0;
   logic [7:0]  req_position = '0;
   logic        rsp_valid;
   status_type  rsp_status;
   logic [63:0] rsp_out_key;
   logic [63:0] rsp_out_value;
   logic [7:0]  rsp_next_position;

   int          head_of_bucket[BUCKETS];
   logic [63:0] slot_key[ENTRIES];
   logic [63:0] slot_value[ENTRIES];
   logic [31:0] slot_hash[ENTRIES];
   int          slot_link[ENTRIES];
   logic        slot_live[ENTRIES];
   int          live_slots;
   int          filled_slots;

   map_result_type pending_results[$];
   int             error_count = 0;

   logic [63:0] key_pool[16];
   logic [31:0] hash_pool[16];

   ordered_chained_hash_map uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_key(req_key), .req_key_hash(req_key_hash),
      .req_value(req_value), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_key(rsp_out_key),
      .rsp_out_value(rsp_out_value), .rsp_next_position(rsp_next_position)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int bucket_index(logic [31:0] h);
      return int'(h[31:24]);
   endfunction

   function automatic int lookup_slot(logic [63:0] k, logic [31:0] h);
      int at;
      int steps;
      at = head_of_bucket[bucket_index(h)];
      steps = 0;
      while (at >= 0 && at < filled_slots && steps < ENTRIES) begin
         if (slot_live[at] && slot_key[at] == k) return at;
         at = slot_link[at];
         steps++;
      end
      return NO_LINK;
   endfunction

   function automatic logic [31:0] slot_hash_of(logic [63:0] k);
      for (int i = 0; i < filled_slots; i++)
         if (slot_live[i] && slot_key[i] == k) return slot_hash[i];
      return 32'h0;
   endfunction

   function automatic void chain_slot(int s);
      int b;
      b = bucket_index(slot_hash[s]);
      slot_link[s] = head_of_bucket[b];
      head_of_bucket[b] = s;
   endfunction

   function automatic void squeeze_tombstones();
      int j;
      j = 0;
      for (int i = 0; i < BUCKETS; i++) head_of_bucket[i] = NO_LINK;
      for (int i = 0; i < filled_slots; i++) begin
         if (slot_live[i]) begin
            if (i != j) begin
               slot_key[j] = slot_key[i];
               slot_value[j] = slot_value[i];
               slot_hash[j] = slot_hash[i];
               slot_live[j] = 1'b1;
               slot_live[i] = 1'b0;
            end
            chain_slot(j);
            j++;
         end
      end
      filled_slots = j;
      live_slots = j;
   endfunction

   function automatic map_result_type apply_request(req_op_type op, logic [63:0] k,
                                                    logic [31:0] h, logic [63:0] v,
                                                    logic [7:0] p);
      map_result_type r;
      int at;
      r.status = ST_MISS;
      r.out_key = '0;
      r.out_value = '0;
      r.next_position = '0;
      at = (op != OP_NEXT && live_slots != 0) ? lookup_slot(k, h) : NO_LINK;
      case (op)
         OP_GET: begin
            if (at != NO_LINK) begin
               r.status = ST_HIT;
               r.out_value = slot_value[at];
            end
         end
         OP_SET: begin
            if (at != NO_LINK) begin
               slot_value[at] = v;
               r.status = ST_UPDATED;
            end else begin
               if (filled_slots >= ENTRIES && live_slots < filled_slots)
                  squeeze_tombstones();
               if (filled_slots >= ENTRIES) begin
                  r.status = ST_FULL;
               end else begin
                  slot_key[filled_slots] = k;
                  slot_value[filled_slots] = v;
                  slot_hash[filled_slots] = h;
                  slot_live[filled_slots] = 1'b1;
                  chain_slot(filled_slots);
                  filled_slots++;
                  live_slots++;
                  r.status = ST_INSERTED;
               end
            end
         end
         OP_DELETE: begin
            if (at != NO_LINK) begin
               slot_live[at] = 1'b0;
               live_slots--;
               r.status = ST_HIT;
            end
         end
         default: begin
            for (int i = int'(p); i < filled_slots; i++) begin
               if (slot_live[i]) begin
                  r.status = ST_HIT;
                  r.out_key = slot_key[i];
                  r.out_value = slot_value[i];
                  r.next_position = 8'(i + 1);
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n = 1;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_request(req_op_type op, logic [63:0] k, logic [31:0] h,
                               logic [63:0] v, logic [7:0] p);
      req_type <= op;
      req_key <= k;
      req_key_hash <= h;
      req_value <= v;
      req_position <= p;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_request(op, k, h, v, p));
      start <= 1'b0;
      idle_gap();
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      map_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status || rsp_out_key !== e.out_key ||
                rsp_out_value !== e.out_value || rsp_next_position !== e.next_position) begin
               $display("%0t: expected %0d %h %h %0d, actual %0d %h %h %0d", $time,
                        e.status, e.out_key, e.out_value, e.next_position, rsp_status,
                        rsp_out_key, rsp_out_value, rsp_next_position);
               error_count++;
            end
         end
      end
   end

   task automatic test_directed();
      send_request(OP_GET, 64'h1, 32'h0, 64'h0, 8'd0);
      send_request(OP_DELETE, 64'h1, 32'h0, 64'h0, 8'd0);
      send_request(OP_NEXT, 64'h0, 32'h0, 64'h0, 8'd0);
      send_request(OP_SET, '0, '0, '1, 8'd0);
      send_request(OP_SET, '1, '1, '0, 8'd0);
      send_request(OP_SET, 64'h5, 32'hFF00_0000, 64'h55, 8'd0);
      send_request(OP_SET, 64'h5, 32'hFF00_0000, 64'h66, 8'd0);
      send_request(OP_GET, '1, '1, 64'h0, 8'd0);
      send_request(OP_GET, 64'h5, 32'hFF00_0000, 64'h0, 8'd0);
      send_request(OP_GET, 64'h6, 32'hFF00_0000, 64'h0, 8'd0);
      send_request(OP_DELETE, 64'h7, 32'h0, 64'h0, 8'd0);
      send_request(OP_DELETE, '0, '0, 64'h0, 8'd0);
      send_request(OP_NEXT, 64'h0, 32'h0, 64'h0, 8'd0);
      send_request(OP_NEXT, 64'h0, 32'h0, 64'h0, 8'd2);
      send_request(OP_NEXT, 64'h0, 32'h0, 64'h0, 8'd3);
      send_request(OP_NEXT, '1, '1, '1, 8'd192);
      send_request(OP_NEXT, '1, '1, '1, 8'd255);
      send_request(OP_GET, '0, '0, 64'h0, 8'd0);
   endtask

   task automatic test_fill_and_compact();
      for (int i = 0; i < 200; i++)
         send_request(OP_SET, 64'h100 + i, $urandom, {$urandom, $urandom}, 8'd0);
      send_request(OP_SET, 64'hABC, 32'h1234_5678, 64'h1, 8'd0);
      wait_drained();
      for (int i = 0; i < 40; i++)
         send_request(OP_DELETE, 64'h100 + 3 * i, slot_hash_of(64'h100 + 3 * i),
                      64'h0, 8'd0);
      for (int i = 0; i < 45; i++)
         send_request(OP_SET, 64'h900 + i, $urandom, {$urandom, $urandom}, 8'd0);
      for (int p = 0; p < 193; p += 7)
         send_request(OP_NEXT, 64'h0, 32'h0, 64'h0, 8'(p));
   endtask

   task automatic test_random();
      int op_pick;
      int idx;
      logic [63:0] v;
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         hash_pool[i] = (i < 6) ? {8'h3C, 24'($urandom)} : $urandom;
      end
      for (int n = 0; n < 1500; n++) begin
         op_pick = $urandom_range(0, 9);
         idx = $urandom_range(0, 15);
         v = {$urandom, $urandom};
         if ($urandom_range(0, 19) == 0)
            send_request(req_op_type'(op_pick % 4), {$urandom, $urandom}, $urandom, v,
                         8'($urandom));
         else if (op_pick < 3)
            send_request(OP_SET, key_pool[idx], hash_pool[idx], v, 8'd0);
         else if (op_pick < 5)
            send_request(OP_GET, key_pool[idx], hash_pool[idx], v, 8'd0);
         else if (op_pick < 7)
            send_request(OP_DELETE, key_pool[idx], hash_pool[idx], v, 8'd0);
         else
            send_request(OP_NEXT, v, $urandom, v, 8'($urandom_range(0, 200)));
         if (n == 700) wait_drained();
      end
   endtask

   initial begin
      for (int i = 0; i < BUCKETS; i++) head_of_bucket[i] = NO_LINK;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_live[i] = 1'b0;
         slot_link[i] = 0;
      end
      live_slots = 0;
      filled_slots = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_compact();
      test_random();
      wait_drained();
      repeat (800) @(posedge clock);
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
